// ===== hw/rtl/fhp_pkg.sv =====
// shared types, constants and result codes for the frame header parser
package fhp_pkg;

	// default frame length limit, in bytes
	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

	// ethertypes
	localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86dd;

	// ip protocol numbers with a known transport header length
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_IGMP = 8'd2;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// header offsets and lengths in bytes
	localparam logic [6:0] L3_OFFSET_PLAIN = 7'd14;
	localparam logic [6:0] L3_OFFSET_VLAN  = 7'd18;
	localparam logic [6:0] IPV6_HDR_LEN    = 7'd40;
	localparam logic [6:0] SHORT_L4_LEN    = 7'd8;
	localparam logic [6:0] TCP_HDR_LEN     = 7'd20;

	// result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_TYPE   = 2'd1;
	localparam logic [1:0] STATUS_BAD_PROTO  = 2'd2;
	localparam logic [1:0] STATUS_TRUNCATED  = 2'd3;

	// one input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} fhp_in_t;

	// one result transaction
	typedef struct packed {
		logic [15:0] ether_type;
		logic        vlan_present;
		logic [7:0]  ip_protocol;
		logic [6:0]  l3_offset;
		logic [6:0]  l4_offset;
		logic [6:0]  payload_offset;
		logic [15:0] header_checksum;
		logic [11:0] frame_length;
		logic [1:0]  status;
	} fhp_out_t;

endpackage

// ===== hw/rtl/fhp_parse.sv =====
// per-byte header state, checksum accumulation and end-of-frame result
module fhp_parse #(
	parameter int unsigned MAX_FRAME_BYTES = fhp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  fhp_pkg::fhp_in_t in_item,
	output fhp_pkg::fhp_out_t result
);
	import fhp_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

	// end-around carry fold of an 18-bit partial sum
	function automatic logic [16:0] fold16(input logic [17:0] x);
		return {1'b0, x[15:0]} + 17'(x[17:16]);
	endfunction

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [15:0]      type_q, type_n;
	logic             tag_q, tag_n;
	logic [7:0]       proto_q, proto_n;
	logic [3:0]       ihl_q, ihl_n;
	logic [16:0]      sum_q, sum_n;
	logic [7:0]       hh_q, hh_n;

	logic [6:0]       l3_n;
	logic [CNT_W-1:0] hdr_off;
	logic [5:0]       hdr_pos;
	logic [5:0]       hlen_n;
	logic [7:0]       hdr_val;

	// state update for the byte in flight
	always_comb begin
		cnt_n   = cnt_q;
		type_n  = type_q;
		tag_n   = tag_q;
		proto_n = proto_q;
		ihl_n   = ihl_q;
		sum_n   = sum_q;
		hh_n    = hh_q;
		l3_n    = tag_q ? L3_OFFSET_VLAN : L3_OFFSET_PLAIN;
		hdr_off = cnt_q - CNT_W'(l3_n);
		hdr_pos = hdr_off[5:0];
		hlen_n  = {ihl_q, 2'b00};
		hdr_val = in_item.data_byte;
		if (cnt_q < CNT_MAX) begin
			// outer ethertype, then the inner one behind a single vlan tag
			if (cnt_q == CNT_W'(12)) type_n = {in_item.data_byte, 8'h00};
			if (cnt_q == CNT_W'(13)) begin
				type_n = {type_q[15:8], in_item.data_byte};
				if (type_n == ETH_TYPE_VLAN) tag_n = 1'b1;
			end
			if (tag_n && cnt_q == CNT_W'(16)) type_n = {in_item.data_byte, 8'h00};
			if (tag_n && cnt_q == CNT_W'(17)) type_n = {type_q[15:8], in_item.data_byte};
			l3_n    = tag_n ? L3_OFFSET_VLAN : L3_OFFSET_PLAIN;
			hdr_off = cnt_q - CNT_W'(l3_n);
			hdr_pos = hdr_off[5:0];
			// ipv4 header fields and checksum words
			if (type_n == ETH_TYPE_IPV4 && cnt_q >= CNT_W'(l3_n) && hdr_off < CNT_W'(64)) begin
				if (hdr_pos == 6'd0) ihl_n = in_item.data_byte[3:0];
				if (hdr_pos == 6'd9) proto_n = in_item.data_byte;
				hlen_n = {ihl_n, 2'b00};
				if (hdr_pos < hlen_n) begin
					// checksum field itself counts as zero
					if (hdr_pos == 6'd10 || hdr_pos == 6'd11) hdr_val = 8'h00;
					if (!hdr_pos[0]) begin
						hh_n = hdr_val;
					end else begin
						sum_n = fold16({1'b0, sum_q} + {2'b00, hh_q, hdr_val});
					end
				end
			end
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	logic             is_v4;
	logic             is_v6;
	logic [5:0]       hlen_r;
	logic [6:0]       l4_r;
	logic [6:0]       pay_r;
	logic [1:0]       status_r;
	logic [CNT_W-1:0] hb_diff;
	logic             odd_tail;
	logic [16:0]      sum_t;
	logic [16:0]      sum_f;

	// frame summary from the state after this byte
	always_comb begin
		is_v4    = (type_n == ETH_TYPE_IPV4);
		is_v6    = (type_n == ETH_TYPE_IPV6);
		hlen_r   = {ihl_n, 2'b00};
		hb_diff  = cnt_n - CNT_W'(l3_n);
		odd_tail = (cnt_n > CNT_W'(l3_n)) && (hb_diff < CNT_W'(hlen_r)) && hb_diff[0];
		sum_t    = odd_tail ? fold16({1'b0, sum_n} + {2'b00, hh_n, 8'h00}) : sum_n;
		sum_f    = fold16({1'b0, fold16({1'b0, sum_t})});
		status_r = STATUS_OK;
		if (is_v4) begin
			l4_r = l3_n + {1'b0, hlen_r};
			if (proto_n == PROTO_ICMP || proto_n == PROTO_IGMP || proto_n == PROTO_UDP) begin
				pay_r = l4_r + SHORT_L4_LEN;
			end else if (proto_n == PROTO_TCP) begin
				pay_r = l4_r + TCP_HDR_LEN;
			end else begin
				pay_r    = l4_r;
				status_r = STATUS_BAD_PROTO;
			end
		end else if (is_v6) begin
			l4_r  = l3_n + IPV6_HDR_LEN;
			pay_r = l4_r;
		end else begin
			l4_r     = l3_n;
			pay_r    = l3_n;
			status_r = STATUS_BAD_TYPE;
		end
		// truncation overrides the other codes
		if (cnt_n < CNT_W'(pay_r)) status_r = STATUS_TRUNCATED;

		result.ether_type      = type_n;
		result.vlan_present    = tag_n;
		result.ip_protocol     = is_v4 ? proto_n : 8'h00;
		result.l3_offset       = l3_n;
		result.l4_offset       = l4_r;
		result.payload_offset  = pay_r;
		result.header_checksum = is_v4 ? ~sum_f[15:0] : 16'h0000;
		result.frame_length    = 12'(cnt_n);
		result.status          = status_r;
	end

	// state registers, cleared after the last byte of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			type_q  <= '0;
			tag_q   <= 1'b0;
			proto_q <= '0;
			ihl_q   <= '0;
			sum_q   <= '0;
			hh_q    <= '0;
		end else if (step) begin
			if (in_item.last_byte) begin
				cnt_q   <= '0;
				type_q  <= '0;
				tag_q   <= 1'b0;
				proto_q <= '0;
				ihl_q   <= '0;
				sum_q   <= '0;
				hh_q    <= '0;
			end else begin
				cnt_q   <= cnt_n;
				type_q  <= type_n;
				tag_q   <= tag_n;
				proto_q <= proto_n;
				ihl_q   <= ihl_n;
				sum_q   <= sum_n;
				hh_q    <= hh_n;
			end
		end
	end

endmodule

// ===== hw/rtl/frame_header_parser_ip_checksum.sv =====
// Ethernet/IPv4 header parser with IPv4 header checksum. One frame byte is
// taken per transaction, in wire order, with last_byte set on the final
// byte; that byte yields one result transaction (ethertype after at most one
// VLAN tag, offsets, protocol, checksum, length, status) and all other bytes
// yield none. A byte is accepted every cycle unless in_stall is raised: it
// passes an input register, then the parse logic updates the per-frame
// state, and a result is held in an output register. Bytes that do not end
// a frame keep flowing while a result waits; only a last byte waits behind
// an untaken result. Bytes past MAX_FRAME_BYTES are counted no further and
// ignored except for last_byte.
module frame_header_parser_ip_checksum #(
	parameter int unsigned MAX_FRAME_BYTES = fhp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fhp_pkg::fhp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output fhp_pkg::fhp_out_t out_data
);
	import fhp_pkg::*;

	logic     valid_s1;
	fhp_in_t  data_s1;
	logic     advance;
	fhp_out_t result;
	logic     out_valid_q;
	fhp_out_t out_data_q;

	// the stage moves unless a last byte meets a blocked result
	assign advance  = valid_s1 && (!data_s1.last_byte || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	fhp_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.in_item(data_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && data_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && data_s1.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/fhp_checker.sv =====
// port-level checks for the frame header parser, bound to the top level
module fhp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input fhp_pkg::fhp_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input fhp_pkg::fhp_out_t out_data
);
	import fhp_pkg::*;

	// a stalled input transaction holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input changed while stalled");

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// network header starts behind the mac header and optional tag
	a_l3_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.l3_offset == (out_data.vlan_present ? L3_OFFSET_VLAN
			: L3_OFFSET_PLAIN))
		else $error("l3 offset does not match vlan flag");

	// protocol and checksum only reported for ipv4
	a_non_ipv4: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ether_type != ETH_TYPE_IPV4
		|-> out_data.ip_protocol == 8'h00 && out_data.header_checksum == 16'h0000)
		else $error("ipv4 fields set on a non-ipv4 frame");

	// ipv6 header is a fixed length with no transport classification
	a_ipv6_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ether_type == ETH_TYPE_IPV6
		|-> out_data.l4_offset == out_data.l3_offset + IPV6_HDR_LEN
			&& out_data.payload_offset == out_data.l4_offset
			&& out_data.status != STATUS_BAD_TYPE && out_data.status != STATUS_BAD_PROTO)
		else $error("ipv6 offsets or status wrong");

endmodule

bind frame_header_parser_ip_checksum fhp_checker u_fhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for the frame header parser: directed and random frames against a predictor
module tb_top;
	import fhp_pkg::*;

	localparam int unsigned FRAME_LIMIT  = MAX_FRAME_BYTES_DEF;
	localparam int unsigned QUIET_BYTES  = 120;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned ITEM_COUNT   = 1050;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	fhp_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	fhp_out_t out_data;

	// bytes waiting to be sent and frame summaries waiting to come out
	fhp_in_t  frame_bytes[$];
	fhp_out_t expected_summaries[$];

	int unsigned cycle_count    = 0;
	int unsigned cycle_limit    = 0;
	int unsigned bytes_accepted = 0;
	int unsigned quiet_from     = 0;
	int unsigned in_gap_left    = 0;
	int unsigned out_gap_left   = 0;
	int          error_count    = 0;
	bit          byte_taken     = 1'b0;

	// per-frame parse state of the predictor
	logic [11:0] byte_count   = '0;
	logic [15:0] eth_type     = '0;
	logic        vlan_seen    = 1'b0;
	logic [7:0]  proto_byte   = '0;
	logic [3:0]  ihl_words    = '0;
	logic [19:0] hdr_sum      = '0;
	logic [7:0]  pending_high = '0;

	frame_header_parser_ip_checksum #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned fold16(input int unsigned x);
		return (x & 32'hFFFF) + (x >> 16);
	endfunction

	// advance the parse state by one byte, and on the last byte predict the summary
	task automatic parse_frame_byte(input fhp_in_t item);
		int unsigned pos, b, l3, hdr_pos, hdr_len, word, span, s, l4, pay, st, proto;
		fhp_out_t summary;
		pos = 32'(byte_count);
		b = 32'(item.data_byte);
		if (pos < FRAME_LIMIT) begin
			if (pos == 12) eth_type = 16'(b << 8);
			if (pos == 13) begin
				eth_type = eth_type | 16'(b);
				if (eth_type == ETH_TYPE_VLAN) vlan_seen = 1'b1;
			end
			if (vlan_seen && pos == 16) eth_type = 16'(b << 8);
			if (vlan_seen && pos == 17) eth_type = eth_type | 16'(b);
			l3 = 32'(vlan_seen ? L3_OFFSET_VLAN : L3_OFFSET_PLAIN);
			if (eth_type == ETH_TYPE_IPV4 && pos >= l3 && pos - l3 < 64) begin
				hdr_pos = pos - l3;
				if (hdr_pos == 0) ihl_words = b[3:0];
				if (hdr_pos == 9) proto_byte = 8'(b);
				hdr_len = 32'(ihl_words) * 4;
				if (hdr_pos < hdr_len) begin
					// checksum field counts as zero
					word = (hdr_pos == 10 || hdr_pos == 11) ? 0 : b;
					if ((hdr_pos & 1) == 0)
						pending_high = 8'(word);
					else
						hdr_sum = 20'(fold16(32'(hdr_sum)
							+ ((32'(pending_high) << 8) | word)));
				end
			end
			byte_count = 12'(pos + 1);
		end

		if (item.last_byte) begin
			l3 = 32'(vlan_seen ? L3_OFFSET_VLAN : L3_OFFSET_PLAIN);
			st = 32'(STATUS_OK);
			proto = 0;
			s = 0;
			if (eth_type == ETH_TYPE_IPV4) begin
				hdr_len = 32'(ihl_words) * 4;
				proto = 32'(proto_byte);
				l4 = l3 + hdr_len;
				case (proto_byte)
					PROTO_ICMP, PROTO_IGMP, PROTO_UDP: pay = l4 + 32'(SHORT_L4_LEN);
					PROTO_TCP: pay = l4 + 32'(TCP_HDR_LEN);
					default: begin
						pay = l4;
						st = 32'(STATUS_BAD_PROTO);
					end
				endcase
				// header bytes actually seen, odd tail padded with a zero low byte
				span = (32'(byte_count) > l3) ? 32'(byte_count) - l3 : 0;
				if (span > hdr_len) span = hdr_len;
				s = 32'(hdr_sum);
				if ((span & 1) != 0) s = fold16(s + (32'(pending_high) << 8));
				s = fold16(fold16(s));
				s = ~s & 32'hFFFF;
			end else if (eth_type == ETH_TYPE_IPV6) begin
				l4 = l3 + 32'(IPV6_HDR_LEN);
				pay = l4;
			end else begin
				l4 = l3;
				pay = l3;
				st = 32'(STATUS_BAD_TYPE);
			end
			if (32'(byte_count) < pay) st = 32'(STATUS_TRUNCATED);

			summary.ether_type      = eth_type;
			summary.vlan_present    = vlan_seen;
			summary.ip_protocol     = 8'(proto);
			summary.l3_offset       = 7'(l3);
			summary.l4_offset       = 7'(l4);
			summary.payload_offset  = 7'(pay);
			summary.header_checksum = 16'(s);
			summary.frame_length    = byte_count;
			summary.status          = 2'(st);
			expected_summaries.push_back(summary);

			// state clears for the next frame
			byte_count   = '0;
			eth_type     = '0;
			vlan_seen    = 1'b0;
			proto_byte   = '0;
			ihl_words    = '0;
			hdr_sum      = '0;
			pending_high = '0;
		end
	endtask

	function automatic void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endfunction

	task automatic check_summary(input fhp_out_t got);
		fhp_out_t want;
		if (expected_summaries.size() == 0) begin
			$error("unexpected result transaction: %p", got);
			error_count++;
		end else begin
			want = expected_summaries.pop_front();
			compare_field("ether_type", 32'(want.ether_type), 32'(got.ether_type));
			compare_field("vlan_present", 32'(want.vlan_present), 32'(got.vlan_present));
			compare_field("ip_protocol", 32'(want.ip_protocol), 32'(got.ip_protocol));
			compare_field("l3_offset", 32'(want.l3_offset), 32'(got.l3_offset));
			compare_field("l4_offset", 32'(want.l4_offset), 32'(got.l4_offset));
			compare_field("payload_offset", 32'(want.payload_offset),
				32'(got.payload_offset));
			compare_field("header_checksum", 32'(want.header_checksum),
				32'(got.header_checksum));
			compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
			compare_field("status", 32'(want.status), 32'(got.status));
		end
	endtask

	// build one frame and queue its bytes; keep > 0 cuts the frame to that many bytes
	task automatic queue_frame(input bit vlan, input logic [15:0] etype, input int unsigned ihl,
			input logic [7:0] proto, input int unsigned extra, input int unsigned keep);
		logic [7:0] raw[$];
		logic [7:0] first;
		int unsigned hdr_bytes, n;
		fhp_in_t item;
		repeat (12) raw.push_back(8'($urandom));
		if (vlan) begin
			raw.push_back(ETH_TYPE_VLAN[15:8]);
			raw.push_back(ETH_TYPE_VLAN[7:0]);
			repeat (2) raw.push_back(8'($urandom));
		end
		raw.push_back(etype[15:8]);
		raw.push_back(etype[7:0]);
		if (etype == ETH_TYPE_IPV4) begin
			hdr_bytes = (ihl * 4 > 20) ? ihl * 4 : 20;
			first = 8'($urandom);
			first[3:0] = ihl[3:0];
			raw.push_back(first);
			for (n = 1; n < hdr_bytes; n++)
				raw.push_back((n == 9) ? proto : 8'($urandom));
			case (proto)
				PROTO_ICMP, PROTO_IGMP, PROTO_UDP: repeat (SHORT_L4_LEN) raw.push_back(8'($urandom));
				PROTO_TCP: repeat (TCP_HDR_LEN) raw.push_back(8'($urandom));
				default: ;
			endcase
		end else if (etype == ETH_TYPE_IPV6) begin
			repeat (IPV6_HDR_LEN) raw.push_back(8'($urandom));
		end
		repeat (extra) raw.push_back(8'($urandom));
		if (keep > 0)
			while (raw.size() > keep) void'(raw.pop_back());
		foreach (raw[i]) begin
			item.data_byte = raw[i];
			item.last_byte = (i == raw.size() - 1);
			frame_bytes.push_back(item);
		end
	endtask

	// input driver: holds a byte until it is taken, idles in short bursts
	always @(negedge clk) begin : drive_inputs
		logic    next_valid;
		logic    next_stall;
		fhp_in_t next_data;
		bit      quiet;
		quiet = bytes_accepted >= quiet_from;
		next_valid = in_valid;
		next_data = in_data;
		if (arst_n && (!in_valid || byte_taken)) begin
			byte_taken = 1'b0;
			next_valid = 1'b0;
			if (in_gap_left > 0) begin
				in_gap_left--;
			end else if (frame_bytes.size() > 0) begin
				if (!quiet && $urandom_range(0, 5) == 0) begin
					in_gap_left = $urandom_range(0, 3);
				end else begin
					next_valid = 1'b1;
					next_data = frame_bytes[0];
				end
			end
		end
		in_valid <= next_valid;
		in_data <= next_data;

		// result back-pressure
		if (!arst_n) begin
			next_stall = 1'b0;
		end else if (out_gap_left > 0) begin
			next_stall = 1'b1;
			out_gap_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			next_stall = 1'b1;
			out_gap_left = $urandom_range(0, 3);
		end else begin
			next_stall = 1'b0;
		end
		out_stall <= next_stall;
	end

	// monitor: predict on each accepted byte, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (in_valid && !in_stall) begin
				parse_frame_byte(in_data);
				void'(frame_bytes.pop_front());
				bytes_accepted++;
				byte_taken = 1'b1;
			end
			if (out_valid && !out_stall)
				check_summary(out_data);
		end
	end

	initial begin : run_test
		int unsigned kind, ihl, extra, keep;
		bit          vlan;
		logic [15:0] etype;
		logic [7:0]  proto;

		// directed frames: each protocol, ethertype and header corner
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_UDP, 4, 0);
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_TCP, 0, 0);
		queue_frame(1'b1, ETH_TYPE_IPV4, 15, PROTO_ICMP, 3, 0);
		queue_frame(1'b0, ETH_TYPE_IPV4, 6, PROTO_IGMP, 2, 0);
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, 8'hFF, 1, 0);
		queue_frame(1'b0, ETH_TYPE_IPV4, 0, PROTO_UDP, 8, 0);
		queue_frame(1'b1, ETH_TYPE_IPV4, 1, PROTO_TCP, 20, 0);
		queue_frame(1'b0, ETH_TYPE_IPV4, 4, PROTO_UDP, 2, 0);
		queue_frame(1'b0, ETH_TYPE_IPV6, 0, 8'h00, 5, 0);
		queue_frame(1'b1, ETH_TYPE_IPV6, 0, 8'h00, 0, 0);
		queue_frame(1'b0, 16'hFFFF, 0, 8'h00, 10, 0);
		queue_frame(1'b0, 16'h0000, 0, 8'h00, 0, 0);
		// second vlan tag is not skipped
		queue_frame(1'b1, ETH_TYPE_VLAN, 0, 8'h00, 6, 0);
		// truncated frames, some ending on an odd header byte
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_UDP, 0, 1);
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_UDP, 0, 13);
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_UDP, 0, 21);
		queue_frame(1'b1, ETH_TYPE_IPV4, 5, PROTO_UDP, 0, 37);
		queue_frame(1'b0, ETH_TYPE_IPV4, 5, PROTO_UDP, 0, 37);
		queue_frame(1'b1, ETH_TYPE_IPV4, 5, PROTO_TCP, 0, 17);
		queue_frame(1'b0, ETH_TYPE_IPV6, 0, 8'h00, 0, 30);

		// random frames, mostly well formed, up to the byte budget
		while (frame_bytes.size() < ITEM_COUNT) begin
			kind = $urandom_range(0, 99);
			vlan = ($urandom_range(0, 3) == 0);
			ihl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5;
			case ($urandom_range(0, 5))
				0: proto = PROTO_ICMP;
				1: proto = PROTO_IGMP;
				2: proto = PROTO_TCP;
				3, 4: proto = PROTO_UDP;
				default: proto = 8'($urandom);
			endcase
			extra = $urandom_range(0, 10);
			keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : 0;
			if (kind < 65)
				etype = ETH_TYPE_IPV4;
			else if (kind < 80)
				etype = ETH_TYPE_IPV6;
			else if (kind < 85)
				etype = ETH_TYPE_VLAN;
			else
				etype = 16'($urandom);
			queue_frame(vlan, etype, ihl, proto, extra, keep);
		end

		quiet_from = (frame_bytes.size() > QUIET_BYTES) ? frame_bytes.size() - QUIET_BYTES : 0;
		cycle_limit = 30 * frame_bytes.size() + 5000;

		// reset
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			begin
				wait (frame_bytes.size() == 0 && expected_summaries.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			wait (cycle_count >= cycle_limit);
		join_any

		if (cycle_count < cycle_limit && error_count == 0 && expected_summaries.size() == 0)
			$display("frame_header_parser_ip_checksum verification clean");
		else
			$display("frame_header_parser_ip_checksum verification failed");
		$finish;
	end

endmodule
